// File: design/ftni_pkg.sv
// package for the float to normalized integer pixel converter
// format codes and shared types; no dependencies
package ftni_pkg;

    typedef enum logic [2:0] {
        FMT_S8  = 3'd0,
        FMT_U8  = 3'd1,
        FMT_S16 = 3'd2,
        FMT_U16 = 3'd3,
        FMT_S32 = 3'd4,
        FMT_U32 = 3'd5
    } pixel_format_t;

    localparam logic [2:0] FMT_RESET = 3'd1;

    // decoded value after clamp, carried from stage one to stage two
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [2:0]  fmt;
    } clamp_t;

    // scaled magnitude after rounding, stage two to stage three
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [2:0]  fmt;
    } scaled_t;

endpackage

// File: design/ftni_stream_if.sv
// valid/ready stream interface carrying one 32-bit word per beat
// depends on nothing
interface ftni_stream_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/ftni_scale.sv
// stage two logic: multiplies clamped mantissa by format scale, rounds to 24 bits
// depends on ftni_pkg
module ftni_scale (
    input  ftni_pkg::clamp_t  c,
    output ftni_pkg::scaled_t s
);
    logic        is_pos;
    logic [16:0] smant;
    logic [5:0]  sexp;
    logic [40:0] prod;
    logic        top;
    logic [23:0] kept;
    logic        guard;
    logic        sticky;
    logic [24:0] rnd;

    always_comb
    begin
        is_pos = !c.neg;
        smant  = 17'd1;
        sexp   = 6'd0;
        unique case (c.fmt)
            ftni_pkg::FMT_S8:  begin
                if (is_pos) smant = 17'd127; else begin smant = 17'd1; sexp = 6'd7; end
            end
            ftni_pkg::FMT_U8:  smant = 17'd255;
            ftni_pkg::FMT_S16: begin
                if (is_pos) smant = 17'd32767; else begin smant = 17'd1; sexp = 6'd15; end
            end
            ftni_pkg::FMT_U16: smant = 17'd65535;
            ftni_pkg::FMT_S32: begin smant = 17'd1; sexp = 6'd31; end
            default:           begin smant = 17'd1; sexp = 6'd32; end
        endcase
        prod = {17'd0, c.mant} * {24'd0, smant};
        // product of unit mantissa: value = prod * 2^(expo-127-23) * 2^sexp
        // normalize to 24 bits; prod < 2^41
        top    = 1'b0;
        kept   = '0;
        guard  = 1'b0;
        sticky = 1'b0;
        s.expo = '0;
        priority if (prod[40])
        begin
            kept = prod[40:17]; guard = prod[16]; sticky = |prod[15:0];
            s.expo = 8'd17;
        end
        else if (prod[39])
        begin
            kept = prod[39:16]; guard = prod[15]; sticky = |prod[14:0];
            s.expo = 8'd16;
        end
        else if (prod[38])
        begin
            kept = prod[38:15]; guard = prod[14]; sticky = |prod[13:0];
            s.expo = 8'd15;
        end
        else if (prod[37])
        begin
            kept = prod[37:14]; guard = prod[13]; sticky = |prod[12:0];
            s.expo = 8'd14;
        end
        else if (prod[36])
        begin
            kept = prod[36:13]; guard = prod[12]; sticky = |prod[11:0];
            s.expo = 8'd13;
        end
        else if (prod[35])
        begin
            kept = prod[35:12]; guard = prod[11]; sticky = |prod[10:0];
            s.expo = 8'd12;
        end
        else if (prod[34])
        begin
            kept = prod[34:11]; guard = prod[10]; sticky = |prod[9:0];
            s.expo = 8'd11;
        end
        else if (prod[33])
        begin
            kept = prod[33:10]; guard = prod[9]; sticky = |prod[8:0];
            s.expo = 8'd10;
        end
        else if (prod[32])
        begin
            kept = prod[32:9]; guard = prod[8]; sticky = |prod[7:0];
            s.expo = 8'd9;
        end
        else if (prod[31])
        begin
            kept = prod[31:8]; guard = prod[7]; sticky = |prod[6:0];
            s.expo = 8'd8;
        end
        else if (prod[30])
        begin
            kept = prod[30:7]; guard = prod[6]; sticky = |prod[5:0];
            s.expo = 8'd7;
        end
        else if (prod[29])
        begin
            kept = prod[29:6]; guard = prod[5]; sticky = |prod[4:0];
            s.expo = 8'd6;
        end
        else if (prod[28])
        begin
            kept = prod[28:5]; guard = prod[4]; sticky = |prod[3:0];
            s.expo = 8'd5;
        end
        else if (prod[27])
        begin
            kept = prod[27:4]; guard = prod[3]; sticky = |prod[2:0];
            s.expo = 8'd4;
        end
        else if (prod[26])
        begin
            kept = prod[26:3]; guard = prod[2]; sticky = |prod[1:0];
            s.expo = 8'd3;
        end
        else if (prod[25])
        begin
            kept = prod[25:2]; guard = prod[1]; sticky = prod[0];
            s.expo = 8'd2;
        end
        else if (prod[24])
        begin
            kept = prod[24:1]; guard = prod[0];
            s.expo = 8'd1;
        end
        else
        begin
            kept = prod[23:0];
            top  = 1'b1;
        end
        rnd = {1'b0, kept};
        if (guard && (sticky || kept[0]))
            rnd = rnd + 25'd1;
        s.mant = rnd[24] ? rnd[24:1] : rnd[23:0];
        // exponent of leading one relative to unit place, biased by 127
        s.expo = c.expo + s.expo + {2'd0, sexp} + {7'd0, rnd[24]};
        s.zero = c.zero || (top && kept == 24'd0);
        s.neg  = c.neg;
        s.fmt  = c.fmt;
    end
endmodule

// File: design/float_to_norm_int_pixel_core.sv
// top level of the float to normalized integer pixel converter
// depends on ftni_pkg, ftni_stream_if and ftni_scale
//
// usage
//   in  : sink of ftni_stream_if, one single-precision pixel per beat
//   out : source of ftni_stream_if, one integer pixel per beat, zero-extended
//   pixel_format_we / pixel_format_wdata write the format register
//     (0 s8, 1 u8, 2 s16, 3 u16, 4 s32, 5 u32); write only while idle
// timing
//   three register stages: decode and clamp, scale and round, convert
//   and saturate; each input beat passes through them in that order
//   throughput one beat per cycle while out.ready is high (three-stage pipeline)
// reset
//   pipeline empties and format returns to u8
// stall
//   when out.ready is low the output stage holds its beat; bubbles still
//   fill up, and in.ready falls only when every stage holds a beat
module float_to_norm_int_pixel_core (
    input  logic               clk,
    input  logic               rst_n,
    ftni_stream_if.sink        in,
    ftni_stream_if.source      out,
    input  logic               pixel_format_we,
    input  logic [2:0]         pixel_format_wdata
);
    logic [2:0] fmt_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    ftni_pkg::clamp_t  c_next, c_reg;
    ftni_pkg::scaled_t s_next, s_reg;
    logic [31:0] pix_next, pix_reg;
    logic nan_next, nan_reg, bad_next, bad_reg;

    assign en3 = !v3_reg || out.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in.ready  = en1;
    assign out.valid = v3_reg;
    assign out.data  = pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= ftni_pkg::FMT_RESET;
        else if (pixel_format_we)
            fmt_reg <= pixel_format_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage one: decode, nan, clamp to [-1,1]
    always_comb
    begin
        logic [7:0] e;
        logic [22:0] f;
        e = in.data[30:23];
        f = in.data[22:0];
        nan_next = (e == 8'hFF) && (f != 23'd0);
        bad_next = (fmt_reg > ftni_pkg::FMT_U32);
        c_next.neg  = in.data[31];
        c_next.fmt  = fmt_reg;
        c_next.zero = (e == 8'd0) && (f == 23'd0);
        if (e >= 8'd127)
        begin
            c_next.expo = 8'd127;
            c_next.mant = 24'h800000;
        end
        else if (e == 8'd0)
        begin
            c_next.expo = 8'd1;
            c_next.mant = {1'b0, f};
        end
        else
        begin
            c_next.expo = e;
            c_next.mant = {1'b1, f};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            c_reg   <= c_next;
            nan_reg <= nan_next | bad_next;
        end
        if (en2)
        begin
            s_reg   <= s_next;
            bad_reg <= nan_reg;
        end
        if (en3)
            pix_reg <= pix_next;
    end

    ftni_scale u_scale (
        .c (c_reg),
        .s (s_next)
    );

    // stage three: truncate toward zero and saturate
    always_comb
    begin
        logic [8:0]  sh;
        logic [55:0] wide;
        logic [32:0] mag;
        logic        big;
        logic [32:0] maxp, maxn;
        logic        is_uns;
        wide   = '0;
        mag    = '0;
        big    = 1'b0;
        sh     = {1'b0, s_reg.expo} - 9'd127;
        is_uns = 1'b0;
        maxp   = '0;
        maxn   = '0;
        unique case (s_reg.fmt)
            ftni_pkg::FMT_S8:  begin maxp = 33'd127;        maxn = 33'd128;        end
            ftni_pkg::FMT_U8:  begin maxp = 33'd255;        is_uns = 1'b1;         end
            ftni_pkg::FMT_S16: begin maxp = 33'd32767;      maxn = 33'd32768;      end
            ftni_pkg::FMT_U16: begin maxp = 33'd65535;      is_uns = 1'b1;         end
            ftni_pkg::FMT_S32: begin maxp = 33'h7FFFFFFF;   maxn = 33'h80000000;   end
            default:           begin maxp = 33'hFFFFFFFF;   is_uns = 1'b1;         end
        endcase
        if (s_reg.zero || s_reg.expo < 8'd127)
            mag = '0;
        else if (sh > 9'd32)
            big = 1'b1;
        else
        begin
            wide = {32'd0, s_reg.mant} << sh[5:0];
            mag  = wide[55:23];
        end
        if (bad_reg)
            pix_next = '0;
        else if (!s_reg.neg)
            pix_next = (big || mag > maxp) ? maxp[31:0] : mag[31:0];
        else if (is_uns)
            pix_next = '0;
        else
        begin
            logic [32:0] m;
            logic [31:0] neg32;
            m = (big || mag > maxn) ? maxn : mag;
            neg32 = 32'd0 - m[31:0];
            unique case (s_reg.fmt)
                ftni_pkg::FMT_S8:  pix_next = {24'd0, neg32[7:0]};
                ftni_pkg::FMT_S16: pix_next = {16'd0, neg32[15:0]};
                default:           pix_next = neg32;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.data))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in.ready |-> v1_reg && v2_reg && v3_reg && !out.ready)
        else $error("input stalled with room in pipeline");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out.ready && v2_reg |=> out.valid)
        else $error("beat lost between stages");
endmodule

// File: tb/sv/tb_float_to_norm_int_pixel_core.sv
`timescale 1ns / 100ps
// testbench for float_to_norm_int_pixel_core: directed and random pixels over all format codes
// depends on ftni_pkg, ftni_stream_if and the converter core
module tb_float_to_norm_int_pixel_core;

    localparam logic [2:0] FMT_UNUSED6 = 3'd6;
    localparam logic [2:0] FMT_UNUSED7 = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [31:0] F_POS_ONE  = 32'h3f80_0000;
    localparam logic [31:0] F_NEG_ONE  = 32'hbf80_0000;
    localparam logic [31:0] F_POS_INF  = 32'h7f80_0000;
    localparam logic [31:0] F_NEG_INF  = 32'hff80_0000;
    localparam logic [31:0] F_QNAN     = 32'h7fc0_0000;
    localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;

    logic        clk;
    logic        rst_n;
    logic        pixel_format_we;
    logic [2:0]  pixel_format_wdata;
    logic [2:0]  cur_format;
    logic [31:0] expected_pixels[$];
    int          fail_count;
    int          cycle_count;
    bit          no_idle;

    ftni_stream_if in_if();
    ftni_stream_if out_if();

    float_to_norm_int_pixel_core u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in                 (in_if.sink),
        .out                (out_if.source),
        .pixel_format_we    (pixel_format_we),
        .pixel_format_wdata (pixel_format_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] norm_pixel(input logic [31:0] bits, input logic [2:0] fmt);
        logic        neg;
        logic [7:0]  expo;
        logic [63:0] mant, prod, q, mag, rem, half, pos_scale, neg_scale, pos_max, neg_max, mask;
        logic        is_unsigned;
        int          e, len, s;
        neg = bits[31];
        expo = bits[30:23];
        is_unsigned = 1'b0;
        case (fmt)
            ftni_pkg::FMT_S8:
            begin
                pos_scale = 127; neg_scale = 128; pos_max = 127; neg_max = 128; mask = 64'hff;
            end
            ftni_pkg::FMT_U8:
            begin
                pos_scale = 255; neg_scale = 255; pos_max = 255; neg_max = 0; mask = 64'hff;
                is_unsigned = 1'b1;
            end
            ftni_pkg::FMT_S16:
            begin
                pos_scale = 32767; neg_scale = 32768; pos_max = 32767; neg_max = 32768;
                mask = 64'hffff;
            end
            ftni_pkg::FMT_U16:
            begin
                pos_scale = 65535; neg_scale = 65535; pos_max = 65535; neg_max = 0;
                mask = 64'hffff;
                is_unsigned = 1'b1;
            end
            ftni_pkg::FMT_S32:
            begin
                pos_scale = 64'd1 << 31; neg_scale = 64'd1 << 31;
                pos_max = (64'd1 << 31) - 1; neg_max = 64'd1 << 31; mask = 64'hffff_ffff;
            end
            ftni_pkg::FMT_U32:
            begin
                pos_scale = 64'd1 << 32; neg_scale = 64'd1 << 32;
                pos_max = 64'hffff_ffff; neg_max = 0; mask = 64'hffff_ffff;
                is_unsigned = 1'b1;
            end
            default: return 32'd0;
        endcase
        if (expo == 8'hff && bits[22:0] != 0)
            return 32'd0;
        if (expo >= 8'd127)
        begin
            mant = 64'd1;
            e = 0;
        end
        else if (expo == 8'd0)
        begin
            mant = {41'd0, bits[22:0]};
            e = -149;
        end
        else
        begin
            mant = {40'd0, 1'b1, bits[22:0]};
            e = int'(expo) - 150;
        end
        if (mant == 0)
            return 32'd0;
        if (is_unsigned && neg)
            return 32'd0;
        prod = mant * (neg ? neg_scale : pos_scale);
        len = 0;
        for (int i = 0; i < 64; i++)
            if (prod[i])
                len = i + 1;
        q = prod;
        if (len > 24)
        begin
            // round to single precision, nearest even
            s = len - 24;
            q = prod >> s;
            rem = prod & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
            e = e + s;
        end
        if (e >= 0)
            mag = q << e;
        else if (-e >= 64)
            mag = 0;
        else
            mag = q >> (-e);
        if (!neg)
            return (mag > pos_max) ? pos_max[31:0] : mag[31:0];
        if (mag > neg_max)
            mag = neg_max;
        return 32'((-mag) & mask);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        logic [31:0] exp_pixel;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected beat: pixel_bits actual %h", out_if.data);
                fail_count++;
            end
            else
            begin
                exp_pixel = expected_pixels.pop_front();
                if (out_if.data !== exp_pixel)
                begin
                    $error("pixel_bits mismatch: expected %h actual %h", exp_pixel, out_if.data);
                    fail_count++;
                end
            end
        end
    end

    // output backpressure
    initial
    begin
        int stall;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!out_if.valid);
        end
    end

    task automatic send_pixel(input logic [31:0] bits);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.data = bits;
        do
            @(posedge clk);
        while (!in_if.ready);
        expected_pixels.push_back(norm_pixel(bits, cur_format));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_format(input logic [2:0] fmt);
        wait_idle();
        pixel_format_we = 1'b1;
        pixel_format_wdata = fmt;
        @(negedge clk);
        pixel_format_we = 1'b0;
        cur_format = fmt;
    endtask

    function automatic logic [31:0] random_pixel();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
        if (pick < 65)
            return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
        if (pick < 75)
            return {1'($urandom), 8'($urandom_range(127, 255)), 23'($urandom_range(0, 3))};
        if (pick < 85)
            return {1'($urandom), 8'd126, 23'h7fffff - 23'($urandom_range(0, 255))};
        return $urandom;
    endfunction

    task automatic test_reset_format();
        logic [31:0] vals[14];
        vals = '{32'h0, F_NEG_ZERO, F_POS_ONE, F_NEG_ONE, F_POS_INF, F_NEG_INF, F_QNAN,
                 32'hffff_ffff, 32'h7f80_0001, 32'h3f7f_ffff, 32'hbf7f_ffff, 32'h0000_0001,
                 32'h7f7f_ffff, 32'h3b80_8081};
        foreach (vals[i])
            send_pixel(vals[i]);
    endtask

    task automatic test_format_extremes();
        logic [2:0] fmts[8];
        fmts = '{ftni_pkg::FMT_S8, ftni_pkg::FMT_U8, ftni_pkg::FMT_S16, ftni_pkg::FMT_U16,
                 ftni_pkg::FMT_S32, ftni_pkg::FMT_U32, FMT_UNUSED6, FMT_UNUSED7};
        foreach (fmts[i])
        begin
            write_format(fmts[i]);
            send_pixel(F_POS_ONE);
            send_pixel(F_NEG_ONE);
        end
    endtask

    task automatic test_random_pixels();
        logic [2:0] fmt;
        for (int phase = 0; phase < 10; phase++)
        begin
            fmt = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            write_format(fmt);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 53; n++)
            begin
                send_pixel(random_pixel());
                if (n == 26 && phase == 3)
                    wait_idle();
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        pixel_format_we = 1'b0;
        pixel_format_wdata = '0;
        cur_format = ftni_pkg::FMT_RESET;
        fail_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_format();
        test_format_extremes();
        test_random_pixels();
        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
